// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 128;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = AW + 1;
  localparam int IDX_W       = 7;
  localparam int KEY_W       = 16;
  localparam int CFG_W       = 8;

  // Command codes on cmd_i
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One table row as stored in the RAM
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] addr;
    logic [KEY_W-1:0] fmt;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Microprogram steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_TSTHI,
    ST_TSTLO,
    ST_LOOP,
    ST_MID,
    ST_PAIR,
    ST_PAIRHI,
    ST_PAIRLO,
    ST_HIT,
    ST_MISS
  } step_e;

  // Condition tested by a step
  typedef enum logic [2:0] {
    CND_GO,
    CND_EMPTY,
    CND_ABOVE,
    CND_BELOW,
    CND_ADJ,
    CND_EQ,
    CND_OUT_FREE
  } cond_e;

  // RAM read address source
  typedef enum logic [1:0] {
    ADR_HI,
    ADR_LO,
    ADR_MID
  } adr_e;

  // Datapath action; CAP/EMIT fire on true, NARROW captures on true, else narrows
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LATCH_MID,
    ACT_NARROW,
    ACT_CAP_MID,
    ACT_CAP_HI,
    ACT_CAP_LO,
    ACT_EMIT_HIT,
    ACT_EMIT_MISS
  } act_e;

  // One control word
  typedef struct packed {
    logic  in_rdy;
    logic  rd_en;
    adr_e  adr;
    cond_e cnd;
    act_e  act;
    step_e on_true;
    step_e on_false;
  } ctrl_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic go;
    logic empty;
    logic above;
    logic below;
    logic adj;
    logic eq;
    logic out_free;
  } flags_t;

  // Microcode ROM
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{1'b1, 1'b0, ADR_HI, CND_GO, ACT_NONE, ST_START, ST_IDLE};
    unique case (s)
      ST_IDLE:   w = '{1'b1, 1'b0, ADR_HI,  CND_GO,       ACT_NONE,      ST_START,  ST_IDLE};
      ST_START:  w = '{1'b0, 1'b1, ADR_HI,  CND_EMPTY,    ACT_NONE,      ST_MISS,   ST_TSTHI};
      ST_TSTHI:  w = '{1'b0, 1'b1, ADR_LO,  CND_ABOVE,    ACT_NONE,      ST_MISS,   ST_TSTLO};
      ST_TSTLO:  w = '{1'b0, 1'b0, ADR_LO,  CND_BELOW,    ACT_NONE,      ST_MISS,   ST_LOOP};
      ST_LOOP:   w = '{1'b0, 1'b1, ADR_MID, CND_ADJ,      ACT_LATCH_MID, ST_PAIR,   ST_MID};
      ST_MID:    w = '{1'b0, 1'b0, ADR_MID, CND_EQ,       ACT_NARROW,    ST_HIT,    ST_LOOP};
      ST_PAIR:   w = '{1'b0, 1'b1, ADR_HI,  CND_EQ,       ACT_NONE,      ST_PAIRHI, ST_PAIRHI};
      ST_PAIRHI: w = '{1'b0, 1'b1, ADR_LO,  CND_EQ,       ACT_CAP_HI,    ST_HIT,    ST_PAIRLO};
      ST_PAIRLO: w = '{1'b0, 1'b0, ADR_LO,  CND_EQ,       ACT_CAP_LO,    ST_HIT,    ST_MISS};
      ST_HIT:    w = '{1'b0, 1'b0, ADR_HI,  CND_OUT_FREE, ACT_EMIT_HIT,  ST_IDLE,   ST_HIT};
      ST_MISS:   w = '{1'b0, 1'b0, ADR_HI,  CND_OUT_FREE, ACT_EMIT_MISS, ST_IDLE,   ST_MISS};
      default:   w = '{1'b1, 1'b0, ADR_HI,  CND_GO,       ACT_NONE,      ST_START,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sorted_table_binary_search_unit.sv =====
// Sorted-table lookup. A write word (cmd 0) stores key, address and format at row_index
// and gives no result. A lookup word (cmd 1) binary-searches rows 0..entries_in_use-1
// (clamped to the table depth) and gives exactly one result word. Rows must be sorted by
// ascending key. A small microprogram drives the search; the single RAM port with
// registered read allows one row read per cycle. A lookup stops short of the full search
// when the key is out of range or hits early. One item is worked on at a time. The result
// sits in an output register, so the next item is taken while it waits. entries_in_use is
// to be written through the cfg port only while the unit is idle, which the unit does not
// enforce; rows read before they are written return undefined data.
module sorted_table_binary_search_unit import stbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  // input words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [IDX_W-1:0] row_index_i,
  input  logic [KEY_W-1:0] row_key_i,
  input  logic [KEY_W-1:0] row_address_i,
  input  logic [KEY_W-1:0] row_format_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             found_o,
  output logic [IDX_W-1:0] match_index_o,
  output logic [KEY_W-1:0] match_address_o,
  output logic [KEY_W-1:0] match_format_o
);

  ctrl_t  ctrl;
  flags_t flags;
  logic   taken;
  step_e  step;

  logic [CFG_W-1:0] entries_q;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] key_q;
  logic [AW-1:0]    lo_q, hi_q, mid_q, mid_c;
  logic [AW:0]      sum;
  logic             empty_q;

  logic             in_acc, wr_en, row_in_range, lookup_acc, emit;
  logic [AW-1:0]    rd_addr, ram_addr;
  row_t             wr_row, rd_row;
  logic [ROW_W-1:0] rdata;

  logic [AW-1:0]    res_idx_q;
  logic [KEY_W-1:0] res_addr_q, res_fmt_q;

  logic             out_valid_q, found_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [KEY_W-1:0] out_addr_q, out_fmt_q;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i) begin
      entries_q <= cfg_data_i;
    end
  end

  // Input handshake
  assign in_ready_o   = ctrl.in_rdy;
  assign in_acc       = in_valid_i && in_ready_o;
  assign row_in_range = int'(row_index_i) < TABLE_DEPTH;
  assign wr_en        = in_acc && (cmd_i == CMD_WRITE) && row_in_range;
  assign lookup_acc   = in_acc && (cmd_i == CMD_LOOKUP);

  // Rows in use, clamped to the table depth
  assign cnt = (int'(entries_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_q);

  // Midpoint of the current span
  assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c = sum[AW:1];

  // RAM address select
  always_comb begin
    unique case (ctrl.adr)
      ADR_HI:  rd_addr = hi_q;
      ADR_LO:  rd_addr = lo_q;
      ADR_MID: rd_addr = mid_c;
      default: rd_addr = hi_q;
    endcase
  end

  assign ram_addr = wr_en ? AW'(row_index_i) : rd_addr;
  assign wr_row   = '{key: row_key_i, addr: row_address_i, fmt: row_format_i};

  stbs_ram #(
    .Width (ROW_W),
    .Depth (TABLE_DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .en_i    (wr_en || ctrl.rd_en),
    .we_i    (wr_en),
    .addr_i  (ram_addr),
    .wdata_i (wr_row),
    .rdata_o (rdata)
  );

  assign rd_row = row_t'(rdata);

  // Flags for the sequencer
  assign flags.go       = in_valid_i && (cmd_i == CMD_LOOKUP);
  assign flags.empty    = empty_q;
  assign flags.above    = key_q > rd_row.key;
  assign flags.below    = key_q < rd_row.key;
  assign flags.adj      = (hi_q - lo_q) <= AW'(1);
  assign flags.eq       = key_q == rd_row.key;
  assign flags.out_free = !out_valid_q || out_ready_i;

  stbs_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .taken_o (taken),
    .step_o  (step)
  );

  // Search span and key
  always_ff @(posedge clk_i) begin
    if (lookup_acc) begin
      key_q   <= row_key_i;
      lo_q    <= '0;
      hi_q    <= AW'(cnt - CNT_W'(1));
      empty_q <= (cnt == '0);
    end else if (ctrl.act == ACT_NARROW && !taken) begin
      if (rd_row.key > key_q) begin
        hi_q <= mid_q;
      end else begin
        lo_q <= mid_q;
      end
    end
    if (ctrl.act == ACT_LATCH_MID) begin
      mid_q <= mid_c;
    end
  end

  // Capture the matching row; a hit at the midpoint also captures here
  always_ff @(posedge clk_i) begin
    if (taken && (ctrl.act == ACT_NARROW || ctrl.act == ACT_CAP_MID ||
                  ctrl.act == ACT_CAP_HI || ctrl.act == ACT_CAP_LO)) begin
      res_addr_q <= rd_row.addr;
      res_fmt_q  <= rd_row.fmt;
      unique case (ctrl.act)
        ACT_CAP_HI: res_idx_q <= hi_q;
        ACT_CAP_LO: res_idx_q <= lo_q;
        default:    res_idx_q <= mid_q;
      endcase
    end
  end

  // Output register
  assign emit = taken && (ctrl.act == ACT_EMIT_HIT || ctrl.act == ACT_EMIT_MISS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (ctrl.act == ACT_EMIT_HIT) begin
        found_q    <= 1'b1;
        out_idx_q  <= IDX_W'(res_idx_q);
        out_addr_q <= res_addr_q;
        out_fmt_q  <= res_fmt_q;
      end else begin
        found_q    <= 1'b0;
        out_idx_q  <= '0;
        out_addr_q <= '0;
        out_fmt_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_index_o   = out_idx_q;
  assign match_address_o = out_addr_q;
  assign match_format_o  = out_fmt_q;

  // Checks
  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step != ST_IDLE && !empty_q) |-> lo_q <= hi_q)
    else $error("search span inverted");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step == ST_MID) |-> (lo_q < mid_q) && (mid_q < hi_q))
    else $error("midpoint outside open span");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (match_index_o == '0) && (match_address_o == '0) && (match_format_o == '0))
    else $error("miss word carries nonzero fields");

  a_lookup_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CMD_LOOKUP) |=> step == ST_START)
    else $error("lookup did not start search");

endmodule

// ===== rtl/stbs_ram.sv =====
// Single-port RAM, registered read
module stbs_ram #(
  parameter int Width = 48,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stbs_useq.sv =====
// Microprogram sequencer: step counter, control ROM and branch selection
module stbs_useq import stbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   taken_o,
  output step_e  step_o
);

  step_e step_q, step_d;
  ctrl_t ctrl;
  logic  taken;

  assign ctrl = ucode(step_q);

  // Condition select
  always_comb begin
    unique case (ctrl.cnd)
      CND_GO:       taken = flags_i.go;
      CND_EMPTY:    taken = flags_i.empty;
      CND_ABOVE:    taken = flags_i.above;
      CND_BELOW:    taken = flags_i.below;
      CND_ADJ:      taken = flags_i.adj;
      CND_EQ:       taken = flags_i.eq;
      CND_OUT_FREE: taken = flags_i.out_free;
      default:      taken = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    step_d = taken ? ctrl.on_true : ctrl.on_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o  = ctrl;
  assign taken_o = taken;
  assign step_o  = step_q;

endmodule

// ===== tb/tb_sorted_table_binary_search_unit.sv =====
module tb_sorted_table_binary_search_unit import stbs_pkg::*; ();

  // one input word as driven on the ports
  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] addr;
    logic [KEY_W-1:0] fmt;
  } table_word_t;

  // one result word
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] addr;
    logic [KEY_W-1:0] fmt;
  } answer_t;

  // Shadow copy of the row table plus the queue of answers still owed by the unit
  class search_checker;
    row_t             rows [TABLE_DEPTH];
    logic [CFG_W-1:0] live_rows;
    answer_t          owed_answers[$];
    int               failures;

    function new();
      live_rows = '0;
      failures  = 0;
    endfunction

    function void set_live_rows(logic [CFG_W-1:0] v);
      live_rows = v;
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction

    function answer_t row_hit(int unsigned i);
      answer_t a;
      a.found = 1'b1;
      a.idx   = IDX_W'(i);
      a.addr  = rows[i].addr;
      a.fmt   = rows[i].fmt;
      return a;
    endfunction

    // Halving search over the live rows; the last two rows are tried high first
    function answer_t search_table(logic [KEY_W-1:0] key);
      int unsigned span, lo, hi, mid;
      answer_t     miss;
      miss = '0;
      span = (live_rows > TABLE_DEPTH) ? TABLE_DEPTH : live_rows;
      if (span == 0) return miss;
      lo = 0;
      hi = span - 1;
      if (key > rows[hi].key || key < rows[lo].key) return miss;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (rows[mid].key == key) return row_hit(mid);
        if (rows[mid].key > key) hi = mid;
        else lo = mid;
      end
      if (rows[hi].key == key) return row_hit(hi);
      if (rows[lo].key == key) return row_hit(lo);
      return miss;
    endfunction

    // accepted input word: store a row or queue the lookup answer
    function void note_word(table_word_t w);
      if (w.cmd == CMD_WRITE) begin
        rows[w.idx] = '{key: w.key, addr: w.addr, fmt: w.fmt};
      end else begin
        owed_answers.push_back(search_table(w.key));
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (owed_answers.size() == 0) begin
        $error("unexpected result word: found=%0d match_index=%0d", got.found, got.idx);
        failures++;
        return;
      end
      want = owed_answers.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        failures++;
      end
      if (got.idx !== want.idx) begin
        $error("match_index: expected %0d, got %0d", want.idx, got.idx);
        failures++;
      end
      if (got.addr !== want.addr) begin
        $error("match_address: expected %h, got %h", want.addr, got.addr);
        failures++;
      end
      if (got.fmt !== want.fmt) begin
        $error("match_format: expected %h, got %h", want.fmt, got.fmt);
        failures++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             cmd;
  logic [IDX_W-1:0] row_index;
  logic [KEY_W-1:0] row_key;
  logic [KEY_W-1:0] row_address;
  logic [KEY_W-1:0] row_format;
  logic             out_valid;
  logic             out_ready;
  logic             found;
  logic [IDX_W-1:0] match_index;
  logic [KEY_W-1:0] match_address;
  logic [KEY_W-1:0] match_format;

  search_checker    sb;
  logic [KEY_W-1:0] cur_keys [TABLE_DEPTH];  // keys as last written, for picking lookups
  bit               steady;                  // no idling on either side
  int               hold_len;                // receiver hold-off, in cycles
  int               random_items;

  sorted_table_binary_search_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .row_index_i     (row_index),
    .row_key_i       (row_key),
    .row_address_i   (row_address),
    .row_format_i    (row_format),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .found_o         (found),
    .match_index_o   (match_index),
    .match_address_o (match_address),
    .match_format_o  (match_format)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Send one word: random idle cycles first, then hold valid until taken
  task automatic send_word(table_word_t w);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= w.cmd;
    row_index   <= w.idx;
    row_key     <= w.key;
    row_address <= w.addr;
    row_format  <= w.fmt;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(w);
  endtask

  task automatic put_row(int unsigned idx, logic [KEY_W-1:0] key,
                         logic [KEY_W-1:0] addr, logic [KEY_W-1:0] fmt);
    table_word_t w;
    w = '{cmd: CMD_WRITE, idx: IDX_W'(idx), key: key, addr: addr, fmt: fmt};
    cur_keys[idx] = key;
    send_word(w);
  endtask

  // lookup; the unused fields carry random junk
  task automatic look_up(logic [KEY_W-1:0] key);
    table_word_t w;
    w = '{cmd: CMD_LOOKUP, idx: IDX_W'($urandom), key: key,
          addr: KEY_W'($urandom), fmt: KEY_W'($urandom)};
    send_word(w);
  endtask

  // Stop sending, wait for every answer, then let a lookup's worth of cycles pass
  task automatic drain_unit();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_entries(logic [CFG_W-1:0] v);
    drain_unit();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_live_rows(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill rows 0..n-1; keys dense or spread, sorted or not
  task automatic load_rows(int unsigned n, bit sorted, bit dense, bit ends);
    logic [KEY_W-1:0] fresh_keys[$];
    fresh_keys = {};
    for (int i = 0; i < n; i++) begin
      if (dense) fresh_keys.push_back(KEY_W'($urandom_range(0, 4 * n)));
      else fresh_keys.push_back(KEY_W'($urandom_range(0, 65535)));
    end
    if (sorted) fresh_keys.sort();
    if (sorted && ends && n > 0) begin
      fresh_keys[0]     = '0;
      fresh_keys[n - 1] = '1;
    end
    for (int i = 0; i < n; i++) begin
      put_row(i, fresh_keys[i], KEY_W'($urandom), KEY_W'($urandom));
      random_items++;
    end
  endtask

  // Lookup key: mostly stored keys, then neighbors, range edges, random
  function automatic logic [KEY_W-1:0] pick_key(int unsigned n);
    int unsigned c;
    logic [KEY_W-1:0] k;
    c = $urandom_range(99);
    if (n == 0) return KEY_W'($urandom);
    k = cur_keys[$urandom_range(0, n - 1)];
    if (c < 50) return k;
    if (c < 65) return ($urandom_range(1) != 0) ? k + 1'b1 : k - 1'b1;
    if (c < 75) begin
      unique case ($urandom_range(3))
        0: return cur_keys[0] - 1'b1;
        1: return cur_keys[n - 1] + 1'b1;
        2: return '0;
        default: return '1;
      endcase
    end
    return KEY_W'($urandom);
  endfunction

  // Result side: random ready, long hold-offs on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 35);
      end
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1)
        sb.check_answer('{found: found, idx: match_index,
                          addr: match_address, fmt: match_format});
    end
  end

  initial begin
    int unsigned      cfg_rows, live, pick;
    logic [KEY_W-1:0] sorted_keys[$];

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    cmd          = CMD_WRITE;
    row_index    = '0;
    row_key      = '0;
    row_address  = '0;
    row_format   = '0;
    steady       = 1'b0;
    hold_len     = 0;
    random_items = 0;
    sb           = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // whole table sorted, full key range at the ends, so no lookup ever hits an unwritten row
    for (int i = 0; i < TABLE_DEPTH; i++) sorted_keys.push_back(KEY_W'($urandom));
    sorted_keys.sort();
    sorted_keys[0]               = '0;
    sorted_keys[TABLE_DEPTH - 1] = '1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) put_row(i, sorted_keys[i], '1, '1);
      else if (i == TABLE_DEPTH - 1) put_row(i, sorted_keys[i], '0, '0);
      else put_row(i, sorted_keys[i], KEY_W'($urandom), KEY_W'($urandom));
    end

    // empty table: always a miss
    program_entries(0);
    look_up('0);
    look_up('1);
    // full table: both ends, the middle, a gap key
    program_entries(CFG_W'(TABLE_DEPTH));
    look_up('0);
    look_up('1);
    look_up(cur_keys[64]);
    look_up(cur_keys[63]);
    look_up(cur_keys[10] + 1'b1);
    // count above the depth is clamped
    program_entries('1);
    look_up('1);
    look_up(cur_keys[100]);
    // single row
    program_entries(1);
    look_up('0);
    look_up(16'd1);
    // two rows: the pair check
    program_entries(2);
    look_up(cur_keys[1]);
    look_up(cur_keys[0]);
    look_up(cur_keys[1] + 1'b1);
    // unsorted rows: the halving step steers away from a stored key
    program_entries(3);
    put_row(1, '1, 16'h1234, 16'h5678);
    look_up(cur_keys[2]);
    look_up('1);

    // random phases: new count, new rows, then a stream of lookups with stray writes
    for (int phase = 0; random_items < 1300; phase++) begin
      pick = $urandom_range(99);
      if (pick < 5) cfg_rows = 0;
      else if (pick < 10) cfg_rows = $urandom_range(TABLE_DEPTH + 1, 255);
      else if (pick < 18) cfg_rows = TABLE_DEPTH;
      else if (pick < 30) cfg_rows = $urandom_range(1, 3);
      else cfg_rows = $urandom_range(4, 24);
      live   = (cfg_rows > TABLE_DEPTH) ? TABLE_DEPTH : cfg_rows;
      steady = (phase >= 4 && phase < 8);
      program_entries(CFG_W'(cfg_rows));
      load_rows(live, $urandom_range(99) < 85, $urandom_range(1) != 0,
                $urandom_range(99) < 20);
      // one phase with the result side held off while lookups keep coming
      if (phase == 2) hold_len = 300;
      for (int j = 0; j < 40; j++) begin
        if ($urandom_range(99) < 90) look_up(pick_key(live));
        else put_row($urandom_range(0, TABLE_DEPTH - 1), KEY_W'($urandom),
                     KEY_W'($urandom), KEY_W'($urandom));
        random_items++;
      end
    end
    steady = 1'b0;

    drain_unit();
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_useq.sv
rtl/sorted_table_binary_search_unit.sv
tb/tb_sorted_table_binary_search_unit.sv
